// ----- rtl/frrb_pkg.sv -----
package frrb_pkg;

	// Fixed sizes of the scheduler
	localparam int ADDR_BITS   = 26;
	localparam int THREADS     = 24;
	localparam int THR_W       = 5;
	localparam int TC_W        = 5;
	localparam int QDEPTH      = 512;
	localparam int QA_W        = 9;
	localparam int QC_W        = 10;
	localparam int WL_BITS     = 10;
	localparam int WL_BYTES    = 1 << WL_BITS;
	localparam int CMD_BYTES   = 8;
	localparam int CMD_SHIFT   = 3;
	localparam int CMDS_PER_WL = WL_BYTES / CMD_BYTES;
	localparam int ROW_W       = ADDR_BITS - WL_BITS;
	localparam int CMD_W       = ADDR_BITS + THR_W;
	localparam int BC_W        = 12;
	localparam int PEND_W      = 9;
	localparam int MAX_WINDOW  = 64;
	localparam int WIN_W       = 7;
	localparam int SINCE_W     = 10;
	localparam int TIME_W      = 8;
	localparam int PADDR_W     = 5;

	localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

	// Register indexes
	localparam logic [2:0] REG_PRECHARGE = 3'd0;
	localparam logic [2:0] REG_ACTIVATE  = 3'd1;
	localparam logic [2:0] REG_RESTORE   = 3'd2;
	localparam logic [2:0] REG_CAS       = 3'd3;
	localparam logic [2:0] REG_BURST     = 3'd4;
	localparam logic [2:0] REG_WINDOW    = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0] precharge_time;
		logic [TIME_W-1:0] activate_time;
		logic [TIME_W-1:0] restore_time;
		logic [TIME_W-1:0] cas_latency;
		logic [TIME_W-1:0] burst_time;
		logic [WIN_W-1:0]  reorder_window;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [THR_W-1:0]     thr;
	} cmd_t;

	// Completed burst reported by the row buffer
	typedef struct packed {
		logic             valid;
		logic [THR_W-1:0] thr;
	} dec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PCNT,
		ST_PCHK,
		ST_PWR,
		ST_TRD,
		ST_TLD,
		ST_TWS,
		ST_TSC,
		ST_TFR,
		ST_TFD,
		ST_TROW
	} st_t;

	function automatic logic [ROW_W-1:0] row_of(input logic [ADDR_BITS-1:0] a);
		return a[ADDR_BITS-1:WL_BITS];
	endfunction

endpackage

// ----- rtl/frfcfs_row_buffer_memory_timing.sv -----
// Channel   Handshake             Payload
// config    psel/penable/pwrite   paddr, pwdata -> prdata (pready tied high)
// item in   start && !busy        op, start_address, byte_count, thread
// result    strobe (one cycle)    done_valid, done_thread, overflow
//
// Push: one reorder queue write per cycle, one write per command.
// Tick: the wait-list scan takes one entry per cycle and the row-hit search
// makes one reorder queue read per cycle.
// Reset clears all control state at once; no clearing pass is needed.
// Results are registered from the last work state and cannot be held off.
module frfcfs_row_buffer_memory_timing import frrb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [ADDR_BITS-1:0] start_address,
	input  logic [BC_W-1:0]      byte_count,
	input  logic [THR_W-1:0]     thread,
	output logic                 strobe,
	output logic                 done_valid,
	output logic [THR_W-1:0]     done_thread,
	output logic                 overflow
);

	cfg_t            cfg;
	logic            rq_we, dq_we, rb_load, rb_step, rb_in_valid;
	logic [QA_W-1:0] rq_waddr, rq_raddr, dq_waddr, dq_raddr;
	cmd_t            rq_wdata, rq_rdata, dq_wdata, dq_rdata;
	dec_t            rb_dec;

	frrb_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	frrb_qmem u_reorder (
		.clk, .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
		.raddr(rq_raddr), .rdata(rq_rdata)
	);

	frrb_qmem u_ready (
		.clk, .we(dq_we), .waddr(dq_waddr), .wdata(dq_wdata),
		.raddr(dq_raddr), .rdata(dq_rdata)
	);

	frrb_rowbuf u_rowbuf (
		.clk, .arst_n, .cfg, .load(rb_load), .load_cmd(dq_rdata),
		.step(rb_step), .in_valid(rb_in_valid), .dec(rb_dec)
	);

	frrb_seq u_seq (
		.clk, .arst_n, .cfg, .start, .busy, .op, .start_address, .byte_count,
		.thread, .strobe, .done_valid, .done_thread, .overflow,
		.rq_we, .rq_waddr, .rq_wdata, .rq_raddr, .rq_rdata,
		.dq_we, .dq_waddr, .dq_wdata, .dq_raddr, .dq_rdata,
		.rb_load, .rb_step, .rb_in_valid, .rb_dec
	);

endmodule

// ----- rtl/frrb_ram.sv -----
module frrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/frrb_cfg.sv -----
module frrb_cfg import frrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.precharge_time <= TIME_W'(4);
			cfg_q.activate_time  <= TIME_W'(4);
			cfg_q.restore_time   <= TIME_W'(8);
			cfg_q.cas_latency    <= TIME_W'(4);
			cfg_q.burst_time     <= TIME_W'(4);
			cfg_q.reorder_window <= WIN_W'(16);
		end else if (wr) begin
			unique case (idx)
				REG_PRECHARGE: cfg_q.precharge_time <= pwdata[TIME_W-1:0];
				REG_ACTIVATE:  cfg_q.activate_time  <= pwdata[TIME_W-1:0];
				REG_RESTORE:   cfg_q.restore_time   <= pwdata[TIME_W-1:0];
				REG_CAS:       cfg_q.cas_latency    <= pwdata[TIME_W-1:0];
				REG_BURST:     cfg_q.burst_time     <= pwdata[TIME_W-1:0];
				REG_WINDOW:    cfg_q.reorder_window <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PRECHARGE: prdata = 32'(cfg_q.precharge_time);
			REG_ACTIVATE:  prdata = 32'(cfg_q.activate_time);
			REG_RESTORE:   prdata = 32'(cfg_q.restore_time);
			REG_CAS:       prdata = 32'(cfg_q.cas_latency);
			REG_BURST:     prdata = 32'(cfg_q.burst_time);
			REG_WINDOW:    prdata = 32'(cfg_q.reorder_window);
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- rtl/frrb_rowbuf.sv -----
module frrb_rowbuf import frrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic load,
	input  cmd_t load_cmd,
	input  logic step,
	output logic in_valid,
	output dec_t dec
);

	logic               in_v_q, col_v_q, bus_v_q, open_v_q;
	cmd_t               in_c_q, col_c_q, bus_c_q;
	logic [ROW_W-1:0]   open_row_q;
	logic [SINCE_W-1:0] sp_q, sc_q, sb_q;

	logic               iv, cv, bv, ov;
	cmd_t               cc, bc;
	logic [ROW_W-1:0]   orow;
	logic [SINCE_W-1:0] sp, sc, sb;
	logic [SINCE_W-1:0] t_act, t_res;
	dec_t               d;

	assign in_valid = in_v_q;
	assign dec      = d;

	// one step of activate, column and burst timing
	always_comb begin
		iv = in_v_q; cv = col_v_q; bv = bus_v_q; ov = open_v_q;
		cc = col_c_q; bc = bus_c_q; orow = open_row_q;
		sp = sp_q; sc = sc_q; sb = sb_q;
		d = '0;
		t_act = SINCE_W'(cfg.precharge_time) + SINCE_W'(1) + SINCE_W'(cfg.activate_time);
		t_res = SINCE_W'(cfg.precharge_time) + SINCE_W'(1) + SINCE_W'(cfg.restore_time);
		if (iv) begin
			if (ov && row_of(in_c_q.addr) == orow) begin
				if (sp > t_act && !cv) begin
					cv = 1'b1;
					cc = in_c_q;
					sc = '0;
					iv = 1'b0;
				end
			end else if (sp > t_res && sc > SINCE_W'(cfg.cas_latency)
				&& sb > SINCE_W'(cfg.burst_time)) begin
				orow = row_of(in_c_q.addr);
				ov   = 1'b1;
				sp   = '0;
			end
		end
		if (sc >= SINCE_W'(cfg.cas_latency) && cv && sb > SINCE_W'(cfg.burst_time)) begin
			bv = 1'b1;
			bc = cc;
			cv = 1'b0;
			sb = '0;
		end else if (sb == SINCE_W'(cfg.burst_time) && bv) begin
			d.valid = step;
			d.thr   = bc.thr;
		end
		sp = (sp == SINCE_MAX) ? sp : sp + SINCE_W'(1);
		sb = (sb == SINCE_MAX) ? sb : sb + SINCE_W'(1);
		sc = (sc == SINCE_MAX) ? sc : sc + SINCE_W'(1);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q     <= 1'b0;
			col_v_q    <= 1'b0;
			bus_v_q    <= 1'b0;
			open_v_q   <= 1'b0;
			open_row_q <= '0;
			sp_q       <= SINCE_MAX;
			sc_q       <= SINCE_MAX;
			sb_q       <= SINCE_MAX;
		end else if (load) begin
			in_v_q <= 1'b1;
		end else if (step) begin
			in_v_q     <= iv;
			col_v_q    <= cv;
			bus_v_q    <= bv;
			open_v_q   <= ov;
			open_row_q <= orow;
			sp_q       <= sp;
			sc_q       <= sc;
			sb_q       <= sb;
		end
	end

	// slot payloads
	always_ff @(posedge clk) begin
		if (load) begin
			in_c_q <= load_cmd;
		end else if (step) begin
			col_c_q <= cc;
			bus_c_q <= bc;
		end
	end

endmodule

// ----- rtl/frrb_seq.sv -----
module frrb_seq import frrb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [ADDR_BITS-1:0] start_address,
	input  logic [BC_W-1:0]      byte_count,
	input  logic [THR_W-1:0]     thread,
	output logic                 strobe,
	output logic                 done_valid,
	output logic [THR_W-1:0]     done_thread,
	output logic                 overflow,
	// reorder queue memory
	output logic                 rq_we,
	output logic [QA_W-1:0]      rq_waddr,
	output cmd_t                 rq_wdata,
	output logic [QA_W-1:0]      rq_raddr,
	input  cmd_t                 rq_rdata,
	// ready queue memory
	output logic                 dq_we,
	output logic [QA_W-1:0]      dq_waddr,
	output cmd_t                 dq_wdata,
	output logic [QA_W-1:0]      dq_raddr,
	input  cmd_t                 dq_rdata,
	// row buffer
	output logic                 rb_load,
	output logic                 rb_step,
	input  logic                 rb_in_valid,
	input  dec_t                 rb_dec
);

	st_t                  state_q, state_d;
	logic [ADDR_BITS:0]   a_q, end_q;
	logic [BC_W-1:0]      bc_q;
	logic [THR_W-1:0]     thr_q;
	logic [PEND_W-1:0]    n_q, cnt_q;
	logic [QA_W-1:0]      rq_head_q, dq_head_q;
	logic [QC_W-1:0]      rq_cnt_q, dq_cnt_q;
	logic                 sched_v_q;
	logic [ROW_W-1:0]     sched_row_q;
	logic [THR_W-1:0]     wait_q [THREADS];
	logic [PEND_W-1:0]    pend_q [THREADS];
	logic [TC_W-1:0]      wc_q, wi_q;
	logic [WIN_W-1:0]     idx_q, cmp_idx_q;
	logic                 cmp_v_q;
	cmd_t                 front_q;
	logic                 strobe_q, dv_q, ovf_q;
	logic [THR_W-1:0]     dt_q;

	logic                 acc, fin;
	logic [WL_BITS:0]     first;
	logic [BC_W-1:0]      l1, rmd, rem;
	logic [BC_W:0]        n_full;
	logic                 ovf_chk;
	logic [ADDR_BITS:0]   p8, le, nxt;
	logic [THR_W-1:0]     wid;
	logic                 wdone;
	logic [WIN_W-1:0]     win, limit;
	logic                 issue, sc_hit, sc_end;
	cmd_t                 swap_c;

	assign acc         = start && !busy;
	assign busy        = (state_q != ST_IDLE);
	assign strobe      = strobe_q;
	assign done_valid  = dv_q;
	assign done_thread = dt_q;
	assign overflow    = ovf_q;

	// command count of a push and its overflow check
	always_comb begin
		first  = (WL_BITS+1)'(WL_BYTES) - (WL_BITS+1)'(a_q[WL_BITS-1:0]);
		l1     = (bc_q < BC_W'(first)) ? bc_q : BC_W'(first);
		rmd    = bc_q - l1;
		rem    = rmd & BC_W'(WL_BYTES - 1);
		n_full = (BC_W+1)'((l1 + BC_W'(CMD_BYTES - 1)) >> CMD_SHIFT)
			+ (BC_W+1)'((rmd >> WL_BITS) * CMDS_PER_WL)
			+ (BC_W+1)'((rem + BC_W'(CMD_BYTES - 1)) >> CMD_SHIFT);
		ovf_chk = (wc_q >= TC_W'(THREADS))
			|| ((QC_W+1)'(rq_cnt_q) + (QC_W+1)'(dq_cnt_q) + (QC_W+1)'(n_q)
				> (QC_W+1)'(QDEPTH));
	end

	// next command boundary: 8 bytes, wordline end or transfer end
	always_comb begin
		p8  = a_q + (ADDR_BITS+1)'(CMD_BYTES);
		le  = {a_q[ADDR_BITS:WL_BITS], {WL_BITS{1'b0}}} + (ADDR_BITS+1)'(WL_BYTES);
		nxt = (p8 < le) ? p8 : le;
		nxt = (nxt < end_q) ? nxt : end_q;
	end

	// wait-list scan entry
	always_comb begin
		wid   = wait_q[wi_q];
		wdone = (wi_q < wc_q) && (wid < THR_W'(THREADS)) && (pend_q[wid] == '0);
	end

	// reorder window search
	always_comb begin
		win    = (cfg.reorder_window > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
			: cfg.reorder_window;
		limit  = !sched_v_q ? '0 : ((rq_cnt_q < QC_W'(win)) ? WIN_W'(rq_cnt_q) : win);
		issue  = (idx_q < limit);
		sc_hit = cmp_v_q && (row_of(rq_rdata.addr) == sched_row_q);
		sc_end = !cmp_v_q && !issue;
		swap_c = (cmp_idx_q == '0) ? rq_rdata : front_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (!op) state_d = ST_TRD;
					else if (thread < THR_W'(THREADS)) state_d = ST_PCNT;
				end
			end
			ST_PCNT: state_d = ST_PCHK;
			ST_PCHK: state_d = ovf_chk ? ST_IDLE : ST_PWR;
			ST_PWR:  if (cnt_q == '0) state_d = ST_IDLE;
			ST_TRD:  state_d = (!rb_in_valid && dq_cnt_q != '0) ? ST_TLD : ST_TWS;
			ST_TLD:  state_d = ST_TWS;
			ST_TWS:  if (wi_q >= wc_q || wdone) state_d = ST_TSC;
			ST_TSC: begin
				if (sc_hit) state_d = ST_TROW;
				else if (sc_end) state_d = ST_TFR;
			end
			ST_TFR:  state_d = (rq_cnt_q != '0) ? ST_TFD : ST_TROW;
			ST_TFD:  state_d = ST_TROW;
			ST_TROW: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		rq_we    = 1'b0;
		rq_waddr = rq_head_q + QA_W'(rq_cnt_q);
		rq_wdata = '{addr: a_q[ADDR_BITS-1:0], thr: thr_q};
		rq_raddr = rq_head_q;
		dq_we    = 1'b0;
		dq_waddr = dq_head_q + QA_W'(dq_cnt_q);
		dq_wdata = rq_rdata;
		dq_raddr = dq_head_q;
		rb_load  = 1'b0;
		rb_step  = 1'b0;
		fin      = 1'b0;
		unique case (state_q)
			ST_IDLE: fin = acc && op && (thread >= THR_W'(THREADS));
			ST_PCHK: fin = ovf_chk;
			ST_PWR: begin
				rq_we = (cnt_q != '0);
				fin   = (cnt_q == '0);
			end
			ST_TLD: rb_load = 1'b1;
			ST_TSC: begin
				rq_raddr = rq_head_q + QA_W'(idx_q);
				if (sc_hit) begin
					rq_we    = 1'b1;
					rq_waddr = rq_head_q + QA_W'(cmp_idx_q);
					rq_wdata = swap_c;
					dq_we    = (dq_cnt_q < QC_W'(QDEPTH));
				end
			end
			ST_TFD: dq_we = (dq_cnt_q < QC_W'(QDEPTH));
			ST_TROW: begin
				rb_step = 1'b1;
				fin     = 1'b1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rq_head_q <= '0;
			rq_cnt_q  <= '0;
			dq_head_q <= '0;
			dq_cnt_q  <= '0;
			sched_v_q <= 1'b0;
			wc_q      <= '0;
			strobe_q  <= 1'b0;
			cmp_v_q   <= 1'b0;
			for (int i = 0; i < THREADS; i++) begin
				pend_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= fin;
			if (rq_we && state_q == ST_PWR) rq_cnt_q <= rq_cnt_q + QC_W'(1);
			if (dq_we) dq_cnt_q <= dq_cnt_q + QC_W'(1);
			unique case (state_q)
				ST_PWR: begin
					if (cnt_q == '0) begin
						pend_q[thr_q] <= n_q;
						wc_q          <= wc_q + TC_W'(1);
					end
				end
				ST_TLD: begin
					dq_head_q <= dq_head_q + QA_W'(1);
					dq_cnt_q  <= dq_cnt_q - QC_W'(1);
				end
				ST_TWS: if (wdone) wc_q <= wc_q - TC_W'(1);
				ST_TSC: begin
					cmp_v_q <= issue && !sc_hit;
					if (sc_hit) begin
						rq_head_q <= rq_head_q + QA_W'(1);
						rq_cnt_q  <= rq_cnt_q - QC_W'(1);
					end
				end
				ST_TFD: begin
					rq_head_q <= rq_head_q + QA_W'(1);
					rq_cnt_q  <= rq_cnt_q - QC_W'(1);
					sched_v_q <= 1'b1;
				end
				ST_TROW: begin
					if (rb_dec.valid && rb_dec.thr < THR_W'(THREADS)
						&& pend_q[rb_dec.thr] != '0) begin
						pend_q[rb_dec.thr] <= pend_q[rb_dec.thr] - PEND_W'(1);
					end
				end
				default: cmp_v_q <= 1'b0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					a_q   <= {1'b0, start_address};
					end_q <= (ADDR_BITS+1)'(start_address) + (ADDR_BITS+1)'(byte_count);
					bc_q  <= byte_count;
					thr_q <= thread;
					dv_q  <= 1'b0;
					dt_q  <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_PCNT: n_q <= n_full[PEND_W-1:0];
			ST_PCHK: begin
				cnt_q <= n_q;
				ovf_q <= ovf_chk;
			end
			ST_PWR: begin
				if (cnt_q != '0) begin
					a_q   <= nxt;
					cnt_q <= cnt_q - PEND_W'(1);
				end else begin
					wait_q[wc_q] <= thr_q;
				end
			end
			ST_TRD: wi_q <= '0;
			ST_TWS: begin
				if (wdone) begin
					wait_q[wi_q] <= wait_q[wc_q - TC_W'(1)];
					dv_q         <= 1'b1;
					dt_q         <= wid;
				end else begin
					wi_q <= wi_q + TC_W'(1);
				end
				idx_q <= '0;
			end
			ST_TSC: begin
				if (issue) idx_q <= idx_q + WIN_W'(1);
				cmp_idx_q <= idx_q;
				if (cmp_v_q && cmp_idx_q == '0) front_q <= rq_rdata;
			end
			ST_TFD: sched_row_q <= row_of(rq_rdata.addr);
			default: ;
		endcase
	end

	// queues never hold more than their shared depth
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(QC_W+1)'(rq_cnt_q) + (QC_W+1)'(dq_cnt_q) <= (QC_W+1)'(QDEPTH))
		else $error("queue occupancy above depth");

	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= TC_W'(THREADS))
		else $error("wait list count above thread count");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !(op && thread >= THR_W'(THREADS)) |=> busy)
		else $error("accepted item did not start work");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(done_valid && overflow))
		else $error("done and overflow together");

	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result while item still at work");

endmodule

// ----- rtl/frrb_ram_wrap_unused_guard.sv -----
module frrb_qmem import frrb_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [QA_W-1:0] waddr,
	input  cmd_t            wdata,
	input  logic [QA_W-1:0] raddr,
	output cmd_t            rdata
);

	logic [CMD_W-1:0] rd;

	// one command queue: address and thread per entry
	frrb_ram #(.WIDTH(CMD_W), .DEPTH(QDEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign rdata = cmd_t'(rd);

endmodule
